/* design/qpe_pkg.sv */
package qpe_pkg;

  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_EQ       = 8'h3D;
  localparam logic [7:0] LIMIT_RESET = 8'd76;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    K_PLAIN,
    K_HEX,
    K_LF
  } kind_t;

  // one encoding command: optional soft break, then the body
  typedef struct packed {
    logic       soft_brk;
    kind_t      kind;
    logic [7:0] ch;
    logic       last;
  } cmd_t;

  typedef enum logic {
    F_RUN,
    F_FLUSH
  } fstate_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] d;
    d = {4'h0, v};
    if (v < 4'd10) begin
      return 8'h30 + d;
    end
    return 8'h41 + d - 8'd10;
  endfunction

endpackage

/* design/quoted_printable_line_encoder.sv */
// Quoted-printable line encoder: text bytes go in one per transaction, encoded characters come
// out one per transaction, with last_of_run on the final character caused by each input
// transaction (an input that only gets buffered yields none). A byte is encoded once the two
// bytes after it, or the end marker, have arrived. The output side delivers one character per
// clock while out_ready is high and a command is waiting; a plain byte yields one character
// and an escaped byte preceded by a soft break up to five. A four-entry command queue between
// the classifier and the character serializer absorbs bursts. An end-of-text transaction
// blocks input while the held bytes and the closing line break are queued, which takes longer
// while the queue is full.
// line_limit is sampled by the classifier and should only be written while the block is idle.
module quoted_printable_line_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last_of_run,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import qpe_pkg::*;

  logic q_push, q_pop, q_full, q_empty;
  cmd_t push_cmd, head_cmd;

  qpe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (push_cmd)
  );

  qpe_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  qpe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_cmd           (head_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  a_flush_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_text |=> !in_ready)
    else $error("input taken during flush");

  a_no_nul_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_char != 8'h00)
    else $error("raw zero byte on output");
`endif

endmodule

/* design/qpe_front.sv */
module qpe_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_text_byte,
  input  logic          in_end_of_text,
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data,
  input  logic          q_full,
  output logic          q_push,
  output qpe_pkg::cmd_t q_cmd
);
  import qpe_pkg::*;

  fstate_t    state_r, state_nxt;
  logic [7:0] pend0_r, pend0_nxt;
  logic [7:0] pend1_r, pend1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] limit_r;

  logic [7:0] w0, w1, w2;
  logic [1:0] n;
  logic       lf_head, brk, ws, plain, soft_brk, used2;
  logic [8:0] sum;
  logic [7:0] k8;
  logic [7:0] enc_len;
  logic [1:0] rem;
  logic       accept;

  assign accept = in_valid && in_ready;

  // window over pending bytes, plus the incoming byte while running
  always_comb begin
    if (state_r == F_RUN) begin
      w0 = (cnt_r == 2'd0) ? in_text_byte : pend0_r;
      w1 = (cnt_r == 2'd1) ? in_text_byte : pend1_r;
      w2 = in_text_byte;
      n  = cnt_r + 2'd1;
    end else begin
      w0 = pend0_r;
      w1 = pend1_r;
      w2 = 8'h00;
      n  = cnt_r;
    end
  end

  // classify the oldest byte of the window
  always_comb begin
    lf_head = (w0 == CH_LF) || (w0 == CH_CR && n > 2'd1 && w1 == CH_LF);
    used2   = lf_head && (w0 == CH_CR);
    brk     = (n <= 2'd1) || (w1 == CH_LF) || (w1 == CH_CR && n > 2'd2 && w2 == CH_LF);
    ws      = (w0 == CH_TAB) || (w0 == CH_SPACE);
    if (ws) begin
      plain = !brk;
    end else begin
      plain = w0 inside {[8'd33:8'd60], [8'd62:8'd126]};
    end
    k8       = plain ? 8'd1 : 8'd3;
    sum      = {1'b0, len_r} + {1'b0, k8};
    soft_brk = !lf_head && ((sum > {1'b0, limit_r}) || (sum == {1'b0, limit_r} && !brk));
    if (lf_head) begin
      enc_len = 8'd0;
    end else if (soft_brk) begin
      enc_len = k8;
    end else begin
      enc_len = sum[7:0];
    end
    rem = used2 ? (cnt_r - 2'd2) : (cnt_r - 2'd1);
  end

  always_comb begin
    state_nxt      = state_r;
    pend0_nxt      = pend0_r;
    pend1_nxt      = pend1_r;
    cnt_nxt        = cnt_r;
    len_nxt        = len_r;
    q_push         = 1'b0;
    q_cmd.soft_brk = soft_brk;
    q_cmd.kind     = lf_head ? K_LF : (plain ? K_PLAIN : K_HEX);
    q_cmd.ch       = w0;
    q_cmd.last     = 1'b1;
    in_ready       = (state_r == F_RUN) && !q_full;
    case (state_r)
      F_RUN: begin
        if (accept) begin
          if (in_end_of_text) begin
            state_nxt = F_FLUSH;
          end else if (cnt_r == 2'd2) begin
            q_push  = 1'b1;
            len_nxt = enc_len;
            if (used2) begin
              pend0_nxt = w2;
              cnt_nxt   = 2'd1;
            end else begin
              pend0_nxt = w1;
              pend1_nxt = w2;
            end
          end else begin
            if (cnt_r == 2'd0) begin
              pend0_nxt = in_text_byte;
            end else begin
              pend1_nxt = in_text_byte;
            end
            cnt_nxt = cnt_r + 2'd1;
          end
        end
      end
      F_FLUSH: begin
        if (cnt_r != 2'd0) begin
          q_cmd.last = (rem == 2'd0) && (enc_len == 8'd0);
          if (!q_full) begin
            q_push    = 1'b1;
            pend0_nxt = w1;
            cnt_nxt   = rem;
            len_nxt   = enc_len;
          end
        end else if (len_r != 8'd0) begin
          // closing line break for a non-empty last line
          q_cmd.soft_brk = 1'b0;
          q_cmd.kind     = K_LF;
          q_cmd.ch       = CH_LF;
          if (!q_full) begin
            q_push    = 1'b1;
            len_nxt   = 8'd0;
            state_nxt = F_RUN;
          end
        end else begin
          state_nxt = F_RUN;
        end
      end
      default: begin
        state_nxt = F_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_RUN;
      cnt_r   <= 2'd0;
      len_r   <= 8'd0;
      limit_r <= LIMIT_RESET;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend0_r <= pend0_nxt;
    pend1_r <= pend1_nxt;
  end

endmodule

/* design/qpe_fifo.sv */
module qpe_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  qpe_pkg::cmd_t push_cmd,
  input  logic          pop,
  output qpe_pkg::cmd_t head_cmd,
  output logic          full,
  output logic          empty
);
  import qpe_pkg::*;

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full     = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* design/qpe_back.sv */
module qpe_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  qpe_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_char,
  output logic          out_last_of_run
);
  import qpe_pkg::*;

  logic       busy_r;
  cmd_t       cmd_r;
  logic [2:0] idx_r;
  logic [2:0] total;
  logic [2:0] body_idx;
  logic       at_end;
  logic       take;

  always_comb begin
    total    = (cmd_r.soft_brk ? 3'd2 : 3'd0) + ((cmd_r.kind == K_HEX) ? 3'd3 : 3'd1);
    at_end   = (idx_r == total - 3'd1);
    body_idx = cmd_r.soft_brk ? (idx_r - 3'd2) : idx_r;
    take     = !busy_r || (out_ready && at_end);
    q_pop    = take && !q_empty;
  end

  always_comb begin
    if (cmd_r.soft_brk && idx_r == 3'd0) begin
      out_char = CH_EQ;
    end else if (cmd_r.soft_brk && idx_r == 3'd1) begin
      out_char = CH_LF;
    end else begin
      case (cmd_r.kind)
        K_PLAIN: out_char = cmd_r.ch;
        K_LF:    out_char = CH_LF;
        K_HEX: begin
          if (body_idx == 3'd0) begin
            out_char = CH_EQ;
          end else if (body_idx == 3'd1) begin
            out_char = hex_digit(cmd_r.ch[7:4]);
          end else begin
            out_char = hex_digit(cmd_r.ch[3:0]);
          end
        end
        default: out_char = CH_LF;
      endcase
    end
  end

  assign out_valid       = busy_r;
  assign out_last_of_run = busy_r && cmd_r.last && at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
    end else if (take) begin
      busy_r <= !q_empty;
      idx_r  <= 3'd0;
    end else if (out_ready) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= q_cmd;
    end
  end

endmodule

/* tb/sv/quoted_printable_line_encoder_test.sv */
module quoted_printable_line_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import qpe_pkg::*;

  localparam int RUN_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam logic [7:0] PRINT_LO = 8'd33;
  localparam logic [7:0] PRINT_HI = 8'd126;
  localparam logic [7:0] CH_DEL = 8'h7F;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } qp_char_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_text_byte = 8'h00;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       out_last_of_run;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;

  // encoder state as predicted
  logic [1:0][7:0] held_byte = '0;
  int              held_count = 0;
  logic [7:0]      line_col = 8'd0;
  logic [7:0]      wrap_limit = LIMIT_RESET;

  qp_char_t   expected_chars[$];
  logic [7:0] step_chars[$];
  int         fail_count = 0;
  int         cycle_count = 0;
  int         hold_cycles = 0;
  bit         tx_gaps_on = 1'b1;
  bit         rx_stalls_on = 1'b1;

  quoted_printable_line_encoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_last_of_run(out_last_of_run),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
    if (nib > 4'd9) begin
      return 8'h37 + {4'h0, nib};
    end
    return 8'h30 + {4'h0, nib};
  endfunction

  // line break or end of text starting at position pos of the window
  function automatic logic break_follows(input logic [2:0][7:0] w, input int n, input int pos);
    if (pos >= n) begin
      return 1'b1;
    end
    if (w[pos] == CH_LF) begin
      return 1'b1;
    end
    return w[pos] == CH_CR && pos + 1 < n && w[pos + 1] == CH_LF;
  endfunction

  task automatic encode_oldest(input logic [2:0][7:0] w, input int n, output int used);
    logic [7:0] c;
    logic       brk;
    logic       plain;
    int         k;
    int         sum;
    c = w[0];
    used = 1;
    if (c == CH_LF || (c == CH_CR && n > 1 && w[1] == CH_LF)) begin
      step_chars.push_back(CH_LF);
      line_col = 8'd0;
      if (c == CH_CR) begin
        used = 2;
      end
    end else begin
      brk = break_follows(w, n, 1);
      if (c == CH_TAB || c == CH_SPACE) begin
        plain = !brk;
      end else begin
        plain = c >= PRINT_LO && c <= PRINT_HI && c != CH_EQ;
      end
      k = plain ? 1 : 3;
      sum = int'(line_col) + k;
      if (sum > int'(wrap_limit) || (sum == int'(wrap_limit) && !brk)) begin
        step_chars.push_back(CH_EQ);
        step_chars.push_back(CH_LF);
        line_col = 8'd0;
      end
      if (plain) begin
        step_chars.push_back(c);
      end else begin
        step_chars.push_back(CH_EQ);
        step_chars.push_back(ascii_hex(c[7:4]));
        step_chars.push_back(ascii_hex(c[3:0]));
      end
      line_col = line_col + 8'(k);
    end
  endtask

  task automatic predict_encoding(input logic [7:0] text_byte, input logic end_of_text);
    logic [2:0][7:0] w;
    int              n;
    int              used;
    int              j;
    qp_char_t        item;
    step_chars.delete();
    w = '0;
    w[0] = held_byte[0];
    w[1] = held_byte[1];
    n = held_count;
    if (end_of_text) begin
      while (n > 0) begin
        encode_oldest(w, n, used);
        if (used > n) begin
          used = n;
        end
        for (j = 0; j + used < n; j++) begin
          w[j] = w[j + used];
        end
        n -= used;
      end
      if (line_col != 8'd0) begin
        step_chars.push_back(CH_LF);
      end
      line_col = 8'd0;
      held_byte = '0;
      held_count = 0;
    end else begin
      w[n] = text_byte;
      n++;
      if (n == 3) begin
        encode_oldest(w, n, used);
        for (j = 0; j + used < n; j++) begin
          w[j] = w[j + used];
        end
        n -= used;
      end
      held_byte[0] = n > 0 ? w[0] : 8'h00;
      held_byte[1] = n > 1 ? w[1] : 8'h00;
      held_count = n;
    end
    for (j = 0; j < step_chars.size(); j++) begin
      item.ch = step_chars[j];
      item.last = j == step_chars.size() - 1;
      expected_chars.push_back(item);
    end
  endtask

  // input transactions are predicted before output transactions are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_encoding(in_text_byte, in_end_of_text);
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("out_char %h arrived with no character expected", out_char);
          fail_count++;
        end else begin
          if (out_char !== expected_chars[0].ch) begin
            $error("out_char: expected %h, got %h", expected_chars[0].ch, out_char);
            fail_count++;
          end
          if (out_last_of_run !== expected_chars[0].last) begin
            $error("out_last_of_run: expected %b, got %b", expected_chars[0].last,
                   out_last_of_run);
            fail_count++;
          end
          void'(expected_chars.pop_front());
        end
      end
    end
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      return $urandom_range(1, 3);
    end else if (r < 96) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
        out_ready <= 1'b0;
        stall_left = idle_length() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic send_text_item(input logic [7:0] text_byte, input logic end_of_text);
    int gap;
    in_valid <= 1'b1;
    in_text_byte <= text_byte;
    in_end_of_text <= end_of_text;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    gap = (tx_gaps_on && $urandom_range(0, 1) == 1) ? idle_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_end();
    send_text_item(8'($urandom), 1'b1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_line_limit(input logic [7:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    wrap_limit = value;
  endtask

  // boundaries of the plain ranges, escapes, whitespace before breaks, cr handling
  task automatic test_byte_classes();
    logic [7:0] seq[$];
    seq = '{"A", 8'd33, 8'd60, CH_EQ, 8'd62, 8'd126, CH_DEL, 8'h00, 8'hFF, 8'h80,
            CH_SPACE, "x", CH_TAB, CH_LF, CH_SPACE, CH_CR, CH_LF, CH_CR, "a", CH_SPACE};
    foreach (seq[i]) begin
      send_text_item(seq[i], 1'b0);
    end
    // trailing space at the end, then an end with nothing on the line
    send_end();
    send_end();
    // cr right before the end
    send_text_item("z", 1'b0);
    send_text_item(CH_CR, 1'b0);
    send_end();
    wait_idle();
  endtask

  task automatic test_random_text(input int items, input logic [7:0] limit,
                                  input int escape_pct, input int break_pct);
    int sent;
    int r;
    int eot_pct;
    write_line_limit(limit);
    eot_pct = break_pct > 0 ? 2 : 0;
    sent = 0;
    while (sent < items) begin
      if (sent % 30 == 0) begin
        tx_gaps_on = $urandom_range(0, 9) < 7;
        rx_stalls_on = $urandom_range(0, 9) < 7;
      end
      r = $urandom_range(0, 99);
      if (r < break_pct) begin
        if ($urandom_range(0, 1) == 1) begin
          send_text_item(CH_CR, 1'b0);
          sent++;
        end
        send_text_item(CH_LF, 1'b0);
      end else if (r < break_pct + 2) begin
        send_text_item(CH_CR, 1'b0);
      end else if (r < break_pct + 2 + eot_pct) begin
        send_end();
      end else if (r < break_pct + 16) begin
        send_text_item($urandom_range(0, 1) == 1 ? CH_SPACE : CH_TAB, 1'b0);
      end else if (r < break_pct + 16 + escape_pct) begin
        case ($urandom_range(0, 3))
          0: send_text_item(8'($urandom_range(0, 31)), 1'b0);
          1: send_text_item(CH_EQ, 1'b0);
          default: send_text_item(8'($urandom_range(127, 255)), 1'b0);
        endcase
      end else begin
        send_text_item(8'($urandom_range(PRINT_LO, PRINT_HI)), 1'b0);
      end
      sent++;
    end
    send_end();
    wait_idle();
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // receiver holds off for a long stretch while the sender keeps offering transactions
  task automatic test_input_stall();
    write_line_limit(8'd9);
    tx_gaps_on = 1'b0;
    hold_cycles = HOLD_OFF_CYCLES;
    repeat (50) begin
      case ($urandom_range(0, 5))
        0: send_text_item(8'($urandom_range(128, 255)), 1'b0);
        1: send_text_item(CH_SPACE, 1'b0);
        2: send_text_item(CH_LF, 1'b0);
        default: send_text_item(8'($urandom_range(PRINT_LO, PRINT_HI)), 1'b0);
      endcase
    end
    send_end();
    wait_idle();
    tx_gaps_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_byte_classes();
    test_random_text(90, 8'd76, 6, 8);
    test_random_text(70, 8'd4, 12, 8);
    test_random_text(130, 8'd255, 50, 0);
    test_random_text(45, 8'($urandom_range(5, 40)), 12, 6);
    test_random_text(15, 8'd2, 12, 8);
    test_random_text(12, 8'd0, 12, 8);
    test_input_stall();
    if (expected_chars.size() != 0) begin
      $error("%0d expected characters never arrived", expected_chars.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
